// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants used by the ARP cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int HEADER_BYTES      = 28;
    localparam int ENTRY_W           = 80;

    localparam logic        ITEM_OP_PACKET = 1'b0;
    localparam logic        ITEM_OP_LOOKUP = 1'b1;
    localparam logic [15:0] OPCODE_REQ     = 16'd1;
    localparam logic [15:0] OPCODE_RSP     = 16'd2;

    typedef struct packed {
        logic        op;
        logic [15:0] packet_len;
        logic [15:0] arp_opcode;
        logic [31:0] ip_addr;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
    } t_arp_in;

    typedef struct packed {
        logic        found;
        logic [47:0] mac_found;
        logic        reply_wanted;
        logic [47:0] reply_dst_mac;
        logic [31:0] reply_dst_ip;
        logic        table_full;
    } t_arp_out;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/arp_cache_table.sv =====
// ----------------------------------------------------------------------------
// arp_cache_table
// IPv4-to-MAC cache: serves lookups and learns from ARP replies, flags
// requests for the own address. Bindings live in one RAM, scanned in order.
// ----------------------------------------------------------------------------
// Lookups and ARP replies pass through ST_SCAN, reading one entry a cycle
//   through the single read port of the entry RAM, then ST_DONE; all other
//   packets go straight to ST_DONE, where the result is registered. busy is
//   high until ST_IDLE, so an item is taken only when the last is through.
// Reset clears the valid bits and own_ip; no clearing pass.
// The result strobe lasts one cycle and cannot be held off.
`default_nettype none

module arp_cache_table #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire arpc_pkg::t_arp_in i_item,
    output logic                   o_result_valid,
    output arpc_pkg::t_arp_out     o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata
);

    import arpc_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state             r_state, n_state;
    t_arp_in            r_item;
    logic [31:0]        r_own_ip;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_idx;
    logic               r_issuing;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [47:0]        r_hit_mac;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    t_arp_out           r_result;
    logic               r_result_valid;

    logic               accept;
    logic               in_scan;
    logic               len_ok;
    logic               is_store;
    logic               is_request;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    t_entry             ram_rdata;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign accept = start && !busy;

    // Lookups and replies walk the table; everything else resolves at once.
    always_comb begin
        in_scan = (i_item.op == ITEM_OP_LOOKUP) ||
                  ((i_item.packet_len >= 16'(HEADER_BYTES)) &&
                   (i_item.arp_opcode == OPCODE_RSP));
    end

    assign len_ok     = r_item.packet_len >= 16'(HEADER_BYTES);
    assign is_store   = (r_item.op == ITEM_OP_PACKET) && len_ok &&
                        (r_item.arp_opcode == OPCODE_RSP);
    assign is_request = (r_item.op == ITEM_OP_PACKET) && len_ok &&
                        (r_item.arp_opcode == OPCODE_REQ) &&
                        (r_item.tgt_ip == r_own_ip);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (r_pend && !r_issuing) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_hit ? r_hit_idx : r_free_idx;
        ram_wdata = '{ip: r_item.ip_addr, mac: r_item.src_mac};
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_SCAN: busy = 1'b1;
            ST_DONE: ram_we = is_store && (r_hit || r_free_ok);
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_own_ip       <= '0;
            r_valid        <= '0;
            r_issuing      <= 1'b0;
            r_pend         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= 1'b0;

            if (i_cfg_we) begin
                r_own_ip <= i_cfg_wdata;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_item    <= i_item;
                        r_idx     <= '0;
                        r_issuing <= 1'b1;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // Compare the entry read last cycle; keep the first match
                    // and the first free slot.
                    if (r_pend) begin
                        if (r_valid[r_pend_idx] && !r_hit &&
                            (ram_rdata.ip == r_item.ip_addr)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_pend_idx;
                            r_hit_mac <= ram_rdata.mac;
                        end
                        if (!r_valid[r_pend_idx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_pend_idx;
                        end
                    end
                    // Advance the read address
                    r_pend     <= r_issuing;
                    r_pend_idx <= r_idx;
                    if (r_issuing) begin
                        if (r_idx == LAST_IDX) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (ram_we && !r_hit) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_result_valid <= 1'b1;
                    r_pend         <= 1'b0;
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_result.found         <= (r_item.op == ITEM_OP_LOOKUP) && r_hit;
            r_result.mac_found     <= ((r_item.op == ITEM_OP_LOOKUP) && r_hit) ?
                                      r_hit_mac : 48'd0;
            r_result.reply_wanted  <= is_request;
            r_result.reply_dst_mac <= is_request ? r_item.src_mac : 48'd0;
            r_result.reply_dst_ip  <= is_request ? r_item.ip_addr : 32'd0;
            r_result.table_full    <= is_store && !r_hit && !r_free_ok;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire
